FILE: hw/rtl/status_tlv_parser_macros.svh
// Assertion macros used by the status TLV parser top level.
`ifndef STATUS_TLV_PARSER_MACROS_SVH
`define STATUS_TLV_PARSER_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define STP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define STP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/stp_pkg.sv
// Types, constants and the record update function of the status TLV parser.
package stp_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_BATTERY   = 3'd0;
  localparam logic [2:0] REG_REMAINING = 3'd1;
  localparam logic [2:0] REG_OVERHEAT  = 3'd2;
  localparam logic [2:0] REG_ENCODING  = 3'd3;
  localparam logic [2:0] REG_LEGACY    = 3'd4;
  localparam logic [2:0] REG_DURATION  = 3'd5;

  // Reset values of the record ids.
  localparam logic [7:0] RST_BATTERY_ID   = 8'd70;
  localparam logic [7:0] RST_REMAINING_ID = 8'd35;
  localparam logic [7:0] RST_OVERHEAT_ID  = 8'd6;
  localparam logic [7:0] RST_ENCODING_ID  = 8'd10;
  localparam logic [7:0] RST_LEGACY_ID    = 8'd8;
  localparam logic [7:0] RST_DURATION_ID  = 8'd13;

  // Encode duration saturates at this value.
  localparam logic [15:0] DURATION_MAX = 16'hFFFF;

  // Record update kinds decoded from a completed record.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_BATTERY,
    OP_REMAINING,
    OP_OVERHEAT,
    OP_RECORDING,
    OP_DURATION
  } op_e;

  // Record ids taken from the configuration registers.
  typedef struct packed {
    logic [7:0] battery;
    logic [7:0] remaining;
    logic [7:0] overheat;
    logic [7:0] encoding;
    logic [7:0] legacy;
    logic [7:0] duration;
  } ids_t;

  // Telemetry record of one slot.
  typedef struct packed {
    logic        battery_known;
    logic [7:0]  battery_percent;
    logic        has_remaining;
    logic [31:0] remaining_seconds;
    logic        has_overheat;
    logic        overheat;
    logic        recording_known;
    logic        recording;
    logic [15:0] encode_seconds;
  } telem_t;

  // Update handed from the parser to the record store, one per accepted word.
  typedef struct packed {
    op_e         op;
    logic [31:0] val;
    logic [1:0]  slot;
    logic        last;
  } upd_t;

  // Stage status of the record store.
  typedef struct packed {
    logic s1_valid;
    logic s1_last;
    logic s1_ok;
  } stat_t;

  // Apply one decoded update to a record.
  function automatic telem_t stp_apply(telem_t r, op_e op, logic [31:0] v);
    telem_t n;
    n = r;
    case (op)
      OP_BATTERY: begin
        n.battery_known   = 1'b1;
        n.battery_percent = v[7:0];
      end
      OP_REMAINING: begin
        n.has_remaining     = 1'b1;
        n.remaining_seconds = v;
      end
      OP_OVERHEAT: begin
        n.has_overheat = 1'b1;
        n.overheat     = v[0];
      end
      OP_RECORDING: begin
        n.recording_known = 1'b1;
        n.recording       = v[0];
      end
      OP_DURATION: begin
        n.encode_seconds = v[15:0];
      end
      default: begin
        n = r;
      end
    endcase
    return n;
  endfunction

endpackage

FILE: hw/rtl/stp_ifs.sv
// Valid/ready channel interfaces for the input byte stream and the result records.

// Input channel: one message byte per word.
interface stp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] slot;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output slot, output data_byte, output last_byte,
                  input ready);
  modport sink (input valid, input slot, input data_byte, input last_byte,
                output ready);
endinterface

// Output channel: one telemetry record per word.
interface stp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_slot;
  logic        battery_known;
  logic [7:0]  battery_percent;
  logic        has_remaining;
  logic [31:0] remaining_seconds;
  logic        has_overheat;
  logic        overheat;
  logic        recording_known;
  logic        recording;
  logic [15:0] encode_seconds;

  modport source (output valid, output out_slot, output battery_known,
                  output battery_percent, output has_remaining,
                  output remaining_seconds, output has_overheat, output overheat,
                  output recording_known, output recording, output encode_seconds,
                  input ready);
  modport sink (input valid, input out_slot, input battery_known,
                input battery_percent, input has_remaining,
                input remaining_seconds, input has_overheat, input overheat,
                input recording_known, input recording, input encode_seconds,
                output ready);
endinterface

FILE: hw/rtl/status_tlv_parser.sv
// Top level of the status TLV parser: configuration, output register and checks.
//
//   Channel  Dir  Word contents                          Handshake
//   in_i     in   slot, data_byte, last_byte              valid/ready
//   out_o    out  slot telemetry record                   valid/ready
//   cfg      in   cfg_idx_i, cfg_wdata_i                  cfg_we_i, no wait
//
// One byte is accepted per cycle unless a finished record stalls in the modify
// stage. The memory read is registered when a byte is accepted, and the modify
// stage then loads the output register, which offers the report.
// A write bypass covers back-to-back bytes on the same slot.
// The slot valid bits are cleared by reset at once; no clearing pass is needed.
// A stalled output holds a finished record while the next bytes keep flowing,
// until a second last byte reaches the modify stage.
`include "status_tlv_parser_macros.svh"

module status_tlv_parser #(
  parameter int SLOTS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stp_in_if.sink    in_i,
  stp_out_if.source out_o,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);
  import stp_pkg::*;

  ids_t   ids_q;
  upd_t   upd;
  telem_t res_rec;
  logic [1:0] res_slot;
  logic   res_valid;
  logic   res_ready;
  logic   store_ready;
  logic   in_fire;
  stat_t  st;
  telem_t out_rec_q;
  logic [1:0] out_slot_q;
  logic   out_valid_q;

  assign in_i.ready = store_ready;
  assign in_fire    = in_i.valid && store_ready;

  // Configuration registers holding the record ids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ids_q.battery   <= RST_BATTERY_ID;
      ids_q.remaining <= RST_REMAINING_ID;
      ids_q.overheat  <= RST_OVERHEAT_ID;
      ids_q.encoding  <= RST_ENCODING_ID;
      ids_q.legacy    <= RST_LEGACY_ID;
      ids_q.duration  <= RST_DURATION_ID;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BATTERY:   ids_q.battery   <= cfg_wdata_i;
        REG_REMAINING: ids_q.remaining <= cfg_wdata_i;
        REG_OVERHEAT:  ids_q.overheat  <= cfg_wdata_i;
        REG_ENCODING:  ids_q.encoding  <= cfg_wdata_i;
        REG_LEGACY:    ids_q.legacy    <= cfg_wdata_i;
        REG_DURATION:  ids_q.duration  <= cfg_wdata_i;
        default:       ids_q           <= ids_q;
      endcase
    end
  end

  // Byte parser.
  stp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .slot_i (in_i.slot),
    .byte_i (in_i.data_byte),
    .last_i (in_i.last_byte),
    .ids_i  (ids_q),
    .upd_o  (upd)
  );

  // Telemetry store.
  stp_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .upd_i       (upd),
    .ready_o     (store_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res_rec),
    .res_slot_o  (res_slot),
    .stat_o      (st)
  );

  // Output register decoupling the store from the result consumer.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_rec_q  <= res_rec;
      out_slot_q <= res_slot;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.out_slot          = out_slot_q;
  assign out_o.battery_known     = out_rec_q.battery_known;
  assign out_o.battery_percent   = out_rec_q.battery_percent;
  assign out_o.has_remaining     = out_rec_q.has_remaining;
  assign out_o.remaining_seconds = out_rec_q.remaining_seconds;
  assign out_o.has_overheat      = out_rec_q.has_overheat;
  assign out_o.overheat          = out_rec_q.overheat;
  assign out_o.recording_known   = out_rec_q.recording_known;
  assign out_o.recording         = out_rec_q.recording;
  assign out_o.encode_seconds    = out_rec_q.encode_seconds;

  // Checks on the store stage and its flow control.
  `STP_ASSERT_NXT(a_fire_fills_stage, clk_i, rst_ni, in_fire, st.s1_valid, "accepted word did not reach the modify stage")
  `STP_ASSERT_NXT(a_last_marks_stage, clk_i, rst_ni, in_fire && in_i.last_byte, st.s1_last, "last byte lost its marker in the modify stage")
  `STP_ASSERT_IMP(a_stall_blocks_input, clk_i, rst_ni, res_valid && !res_ready, !in_fire, "word accepted while a finished record is stalled")

endmodule

FILE: hw/rtl/stp_parse.sv
// Byte-level TLV parser: tracks id, length and value bytes and decodes completed records.
module stp_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [1:0]    slot_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  stp_pkg::ids_t ids_i,
  output stp_pkg::upd_t upd_o
);
  import stp_pkg::*;

  localparam logic [1:0] PH_ID  = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_VAL = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  rid_q, rid_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  seen_q, seen_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] acc_new;
  logic [7:0]  seen_inc;
  logic [7:0]  first;
  logic        complete;
  logic        ge4;
  op_e         op;
  logic [31:0] val;

  assign acc_new  = (seen_q < 8'd4) ? {acc_q[23:0], byte_i} : acc_q;
  assign seen_inc = seen_q + 8'd1;
  assign ge4      = (len_q >= 8'd4);

  // Next parse state for the incoming byte; the last byte of a message rewinds it.
  always_comb begin
    phase_d  = phase_q;
    rid_d    = rid_q;
    len_d    = len_q;
    seen_d   = seen_q;
    acc_d    = acc_q;
    complete = 1'b0;
    case (phase_q)
      PH_ID: begin
        rid_d   = byte_i;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d   = byte_i;
        seen_d  = '0;
        acc_d   = '0;
        phase_d = (byte_i == 8'd0) ? PH_ID : PH_VAL;
      end
      PH_VAL: begin
        acc_d  = acc_new;
        seen_d = seen_inc;
        if (seen_inc >= len_q) begin
          complete = 1'b1;
          phase_d  = PH_ID;
        end
      end
      default: begin
        phase_d = PH_ID;
      end
    endcase
    if (last_i) begin
      phase_d = PH_ID;
      rid_d   = '0;
      len_d   = '0;
      seen_d  = '0;
      acc_d   = '0;
    end
  end

  // The first value byte sits at the top of the kept bytes.
  always_comb begin
    case (len_q)
      8'd1:    first = acc_new[7:0];
      8'd2:    first = acc_new[15:8];
      8'd3:    first = acc_new[23:16];
      default: first = acc_new[31:24];
    endcase
  end

  // Decode the completed record; earlier ids win when several match.
  always_comb begin
    op  = OP_NONE;
    val = {24'd0, first};
    if (complete) begin
      if (rid_q == ids_i.battery) begin
        op = OP_BATTERY;
      end else if (rid_q == ids_i.remaining) begin
        op  = ge4 ? OP_REMAINING : OP_NONE;
        val = acc_new;
      end else if (rid_q == ids_i.overheat) begin
        op  = OP_OVERHEAT;
        val = {31'd0, (first != 8'd0)};
      end else if (rid_q == ids_i.encoding || rid_q == ids_i.legacy) begin
        op  = OP_RECORDING;
        val = {31'd0, (first != 8'd0)};
      end else if (rid_q == ids_i.duration) begin
        op  = ge4 ? OP_DURATION : OP_NONE;
        val = {16'd0, ((acc_new[31:16] != 16'd0) ? DURATION_MAX : acc_new[15:0])};
      end
    end
  end

  assign upd_o.op   = op;
  assign upd_o.val  = val;
  assign upd_o.slot = slot_i;
  assign upd_o.last = last_i;

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID;
      rid_q   <= '0;
      len_q   <= '0;
      seen_q  <= '0;
      acc_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      rid_q   <= rid_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      acc_q   <= acc_d;
    end
  end

endmodule

FILE: hw/rtl/stp_store.sv
// Per-slot telemetry memory with read-modify-write stage, valid bits and write bypass.
module stp_store #(
  parameter int SLOTS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  stp_pkg::upd_t  upd_i,
  output logic           ready_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output stp_pkg::telem_t res_o,
  output logic [1:0]     res_slot_o,
  output stp_pkg::stat_t stat_o
);
  import stp_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  telem_t          mem_q [SLOTS];
  telem_t          rdata_q;
  telem_t          fwd_q;
  telem_t          cur_rec;
  telem_t          new_rec;
  logic [SLOTS-1:0] vld_q;
  logic [4:0]      slot_x;
  logic [AW-1:0]   addr;
  logic            slot_ok;
  logic            s1_valid_q;
  logic            s1_last_q;
  logic            s1_ok_q;
  logic            s1_byp_q;
  logic            s1_rdv_q;
  logic [1:0]      s1_slot_q;
  logic [AW-1:0]   s1_addr_q;
  op_e             s1_op_q;
  logic [31:0]     s1_val_q;
  logic            s1_fire;
  logic            wr_en;

  assign slot_x  = {3'b000, upd_i.slot};
  assign addr    = slot_x[AW-1:0];
  assign slot_ok = (slot_x < 5'(SLOTS));

  // Modify stage: take the freshest copy of the entry and apply the update.
  assign cur_rec = s1_byp_q ? fwd_q : (s1_rdv_q ? rdata_q : '0);
  assign new_rec = stp_apply(cur_rec, s1_op_q, s1_val_q);

  assign res_valid_o = s1_valid_q && s1_last_q && s1_ok_q;
  assign res_o       = new_rec;
  assign res_slot_o  = s1_slot_q;
  assign s1_fire     = s1_valid_q && (!res_valid_o || res_ready_i);
  assign ready_o     = !s1_valid_q || s1_fire;
  assign wr_en       = s1_fire && (s1_op_q != OP_NONE);

  assign stat_o.s1_valid = s1_valid_q;
  assign stat_o.s1_last  = s1_last_q;
  assign stat_o.s1_ok    = s1_ok_q;

  // Memory read port: registered read at accept time.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Memory write port: write back the modified entry.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_addr_q] <= new_rec;
    end
  end

  // Payload of the modify stage and the bypass copy of the last write.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      s1_op_q   <= slot_ok ? upd_i.op : OP_NONE;
      s1_val_q  <= upd_i.val;
      s1_slot_q <= upd_i.slot;
      s1_addr_q <= addr;
    end
    if (wr_en) begin
      fwd_q <= new_rec;
    end
  end

  // Stage control, bypass select and per-entry valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_ok_q    <= 1'b0;
      s1_byp_q   <= 1'b0;
      s1_rdv_q   <= 1'b0;
      vld_q      <= '0;
    end else begin
      if (fire_i) begin
        s1_valid_q <= 1'b1;
        s1_last_q  <= upd_i.last;
        s1_ok_q    <= slot_ok;
        s1_byp_q   <= wr_en && (s1_addr_q == addr);
        s1_rdv_q   <= vld_q[addr];
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_en) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

endmodule
